>>> rtl/tlspq_pkg.sv
package tlspq_pkg;

   localparam int ID_WIDTH   = 16;
   localparam int CAT_WIDTH  = 4;
   localparam int PRIO_WIDTH = 2;
   localparam int CNT_WIDTH  = 5;

   // request action codes
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   // urgency levels, lower is more urgent
   localparam logic [PRIO_WIDTH-1:0] PRIO_NONE = 2'd0;
   localparam logic [PRIO_WIDTH-1:0] PRIO_HIGH = 2'd1;
   localparam logic [PRIO_WIDTH-1:0] PRIO_MID  = 2'd2;
   localparam logic [PRIO_WIDTH-1:0] PRIO_LOW  = 2'd3;

   localparam logic [CAT_WIDTH-1:0] CAT_HIGH_FIRST = 4'd1;
   localparam logic [CAT_WIDTH-1:0] CAT_HIGH_LAST  = 4'd3;
   localparam logic [CAT_WIDTH-1:0] CAT_MID_LAST   = 4'd6;
   localparam logic [CAT_WIDTH-1:0] CAT_LOW_LAST   = 4'd9;

   localparam logic [ID_WIDTH-1:0] ID_FIRST = 16'd1;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_EMPTY  = 2'd1,
      STATUS_BADCAT = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   typedef struct packed {
      logic [PRIO_WIDTH-1:0] level;
      logic [CAT_WIDTH-1:0]  category;
      logic [ID_WIDTH-1:0]   id;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CHK,
      ST_PLACE,
      ST_REM_RD,
      ST_REM_SH,
      ST_OUT
   } state_type;

   function automatic logic [PRIO_WIDTH-1:0] level_of(input logic [CAT_WIDTH-1:0] code);
      logic [PRIO_WIDTH-1:0] lvl;
      lvl = PRIO_NONE;
      if (code >= CAT_HIGH_FIRST && code <= CAT_HIGH_LAST) begin
         lvl = PRIO_HIGH;
      end else if (code > CAT_HIGH_LAST && code <= CAT_MID_LAST) begin
         lvl = PRIO_MID;
      end else if (code > CAT_MID_LAST && code <= CAT_LOW_LAST) begin
         lvl = PRIO_LOW;
      end
      return lvl;
   endfunction

endpackage

>>> rtl/tlspq_ifs.sv
interface tlspq_req_if;
   logic                                valid;
   logic                                ready;
   logic                                action;
   logic [tlspq_pkg::CAT_WIDTH-1:0]     category_code;

   modport source (output valid, output action, output category_code, input ready);
   modport sink   (input valid, input action, input category_code, output ready);
endinterface

interface tlspq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          status;
   logic [tlspq_pkg::ID_WIDTH-1:0]      entry_id;
   logic [tlspq_pkg::CAT_WIDTH-1:0]     entry_category;
   logic [tlspq_pkg::PRIO_WIDTH-1:0]    entry_priority;
   logic [tlspq_pkg::CNT_WIDTH-1:0]     entry_count;

   modport source (output valid, output status, output entry_id, output entry_category,
                   output entry_priority, output entry_count, input ready);
   modport sink   (input valid, input status, input entry_id, input entry_category,
                   input entry_priority, input entry_count, output ready);
endinterface

>>> rtl/three_level_stable_priority_queue.sv
// Three-level stable priority queue.
// req_chan (valid/ready) carries one item: action (0 insert, 1 remove) and a
// category code; codes 1-3 map to level 1, 4-6 to level 2, 7-9 to level 3.
// rsp_chan returns exactly one item per request: status, id, category, level
// and the entry count after the step. Entries sit in a single-port-pair RAM
// kept in service order; one read/compare/write step walks it per entry.
// Steps from accept to rsp valid:
//   insert : read and check held entries from the tail, moving each less urgent
//            one a slot toward the tail, then write the new entry into the freed slot.
//   remove : read held entries from the head on, capture the head, slide the rest toward it.
//   reject (bad code, full, empty): straight to the result stage.
// One item is in flight at a time: req ready only in idle, so a new request
// is taken only once the last has passed to the output register; the RAM's
// registered read splits each entry step into a read state and a check or shift state.
// Reset: queue empty, next id 1. RAM contents are not cleared; only entries
// below the count are ever read, so no clearing pass is run.
// A stalled receiver holds the result in the output register; a finished
// item waits in the result stage until that register frees up.
module three_level_stable_priority_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   tlspq_req_if.sink   req_chan,
   tlspq_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   tlspq_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]         occ_ff, occ_in;
   logic [tlspq_pkg::ID_WIDTH-1:0] seq_ff, seq_in;
   logic [AW-1:0]         k_ff, k_in;
   logic [AW-1:0]         slot_ff, slot_in;
   tlspq_pkg::entry_type  fresh_ff, fresh_in;
   tlspq_pkg::status_type res_status_ff, res_status_in;
   tlspq_pkg::entry_type  res_entry_ff, res_entry_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   tlspq_pkg::status_type rsp_status_ff, rsp_status_in;
   tlspq_pkg::entry_type  rsp_entry_ff, rsp_entry_in;
   logic [tlspq_pkg::CNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   // RAM port signals
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   tlspq_pkg::entry_type  wr_data;
   tlspq_pkg::entry_type  rd_data;
   logic [tlspq_pkg::PRIO_WIDTH-1:0] req_level;

   tlspq_ram #(
      .WIDTH (tlspq_pkg::ENTRY_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (k_ff),
      .rd_data (rd_data)
   );

   assign req_level = tlspq_pkg::level_of(req_chan.category_code);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlspq_pkg::ST_IDLE;
         occ_ff       <= '0;
         seq_ff       <= tlspq_pkg::ID_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      slot_ff       <= slot_in;
      fresh_ff      <= fresh_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      seq_in        = seq_ff;
      k_in          = k_ff;
      slot_in       = slot_ff;
      fresh_in      = fresh_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      wr_en         = 1'b0;
      wr_addr       = k_ff;
      wr_data       = rd_data;
      req_chan.ready = 1'b0;

      case (state_ff)
         tlspq_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               res_entry_in = '0;
               if (req_chan.action == tlspq_pkg::ACT_REMOVE) begin
                  if (occ_ff == '0) begin
                     res_status_in = tlspq_pkg::STATUS_EMPTY;
                     state_in      = tlspq_pkg::ST_OUT;
                  end else begin
                     res_status_in = tlspq_pkg::STATUS_OK;
                     occ_in        = CW'(occ_ff - 1'b1);
                     k_in          = '0;
                     state_in      = tlspq_pkg::ST_REM_RD;
                  end
               end else if (req_level == tlspq_pkg::PRIO_NONE) begin
                  res_status_in = tlspq_pkg::STATUS_BADCAT;
                  state_in      = tlspq_pkg::ST_OUT;
               end else if (occ_ff == CW'(QUEUE_DEPTH)) begin
                  res_status_in = tlspq_pkg::STATUS_FULL;
                  state_in      = tlspq_pkg::ST_OUT;
               end else begin
                  fresh_in.level    = req_level;
                  fresh_in.category = req_chan.category_code;
                  fresh_in.id       = seq_ff;
                  res_entry_in      = fresh_in;
                  res_status_in     = tlspq_pkg::STATUS_OK;
                  seq_in            = seq_ff + 1'b1;
                  occ_in            = CW'(occ_ff + 1'b1);
                  if (occ_ff == '0) begin
                     slot_in  = '0;
                     state_in = tlspq_pkg::ST_PLACE;
                  end else begin
                     k_in     = AW'(occ_ff - 1'b1);
                     state_in = tlspq_pkg::ST_INS_RD;
                  end
               end
            end
         end
         tlspq_pkg::ST_INS_RD: begin
            state_in = tlspq_pkg::ST_INS_CHK;
         end
         tlspq_pkg::ST_INS_CHK: begin
            // move less urgent entries one slot toward the tail
            if (rd_data.level > fresh_ff.level) begin
               wr_en   = 1'b1;
               wr_addr = AW'(k_ff + 1'b1);
               if (k_ff == '0) begin
                  slot_in  = '0;
                  state_in = tlspq_pkg::ST_PLACE;
               end else begin
                  k_in     = AW'(k_ff - 1'b1);
                  state_in = tlspq_pkg::ST_INS_RD;
               end
            end else begin
               slot_in  = AW'(k_ff + 1'b1);
               state_in = tlspq_pkg::ST_PLACE;
            end
         end
         tlspq_pkg::ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_data  = fresh_ff;
            state_in = tlspq_pkg::ST_OUT;
         end
         tlspq_pkg::ST_REM_RD: begin
            state_in = tlspq_pkg::ST_REM_SH;
         end
         tlspq_pkg::ST_REM_SH: begin
            // head is captured, the rest slides one slot toward the head
            if (k_ff == '0) begin
               res_entry_in = rd_data;
            end else begin
               wr_en   = 1'b1;
               wr_addr = AW'(k_ff - 1'b1);
            end
            if (CW'(k_ff) == occ_ff) begin
               state_in = tlspq_pkg::ST_OUT;
            end else begin
               k_in     = AW'(k_ff + 1'b1);
               state_in = tlspq_pkg::ST_REM_RD;
            end
         end
         tlspq_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = res_entry_ff;
               rsp_count_in  = tlspq_pkg::CNT_WIDTH'(occ_ff);
               state_in      = tlspq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tlspq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.entry_id       = rsp_entry_ff.id;
   assign rsp_chan.entry_category = rsp_entry_ff.category;
   assign rsp_chan.entry_priority = rsp_entry_ff.level;
   assign rsp_chan.entry_count    = rsp_count_ff;

   // count never runs past the store
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(QUEUE_DEPTH))
      else $error("occupancy beyond depth");

   // one item in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second item accepted while busy");

   // a good result always names a real level, a rejected one names nothing
   a_rsp_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ((rsp_status_ff == tlspq_pkg::STATUS_OK) ==
          (rsp_entry_ff.level != tlspq_pkg::PRIO_NONE)))
      else $error("result level does not match status");

   // ids are consumed only by a valid insert that fits
   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(seq_ff)) |->
         ($past(state_ff == tlspq_pkg::ST_IDLE && req_chan.valid
                && req_chan.action == tlspq_pkg::ACT_INSERT)
          && $past(occ_ff) != CW'(QUEUE_DEPTH)))
      else $error("sequence id advanced without an insert");

endmodule

>>> rtl/tlspq_ram.sv
module tlspq_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
